FILE: hw/rtl/iperq_pkg.sv
package iperq_pkg;

  localparam int EVENT_DEPTH = 64;
  localparam int BAN_DEPTH   = 16;

  localparam int EV_AW = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;
  localparam int BN_AW = (BAN_DEPTH > 1) ? $clog2(BAN_DEPTH) : 1;
  localparam int BN_CW = $clog2(BAN_DEPTH + 1);

  localparam int FUNC_W     = 2;
  localparam int ADDR_W     = 32;
  localparam int TIME_W     = 32;
  localparam int LIMIT_W    = 7;
  localparam int SEC_W      = 16;
  localparam int COUNT_W    = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IN_W       = 72;
  localparam int OUT_W      = 16;

  localparam logic [FUNC_W-1:0] FUNC_REPORT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_LIFT   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_EVENT_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BAN_TIME    = 2'd2;

  localparam logic [LIMIT_W-1:0] LIMIT_RST  = 7'd5;
  localparam logic [SEC_W-1:0]   WINDOW_RST = 16'd60;
  localparam logic [SEC_W-1:0]   BAN_RST    = 16'd600;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic capture;
    logic ev_wr;
    logic ev_rd;
    logic bn_rd;
    logic bn_rd_last;
    logic lift_wr;
    logic decide;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              ev_last;
    logic              bn_last;
    logic              bn_empty;
    logic              lift_found;
    logic              out_busy;
    logic [BN_CW-1:0]  ban_used;
  } dp_stat_t;

endpackage

FILE: hw/rtl/iperq_ctrl.sv
module iperq_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [iperq_pkg::FUNC_W-1:0]  in_func,
  output logic                          in_ready,
  input  iperq_pkg::dp_stat_t           stat,
  output iperq_pkg::ctrl_cmd_t          cmd
);
  import iperq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_EV_WR, S_EV_SCAN, S_EV_DRAIN, S_DECIDE,
    S_BN_SCAN, S_BN_DRAIN, S_BN_DONE, S_LIFT_RD, S_LIFT_WR, S_FIN
  } state_t;

  state_t state;

  assign in_ready = (state == S_IDLE) && !rst;

  always_comb begin
    cmd            = '0;
    cmd.capture    = in_ready && in_valid;
    cmd.ev_wr      = (state == S_EV_WR);
    cmd.ev_rd      = (state == S_EV_SCAN);
    cmd.bn_rd      = (state == S_BN_SCAN);
    cmd.decide     = (state == S_DECIDE);
    cmd.bn_rd_last = (state == S_LIFT_RD);
    cmd.lift_wr    = (state == S_LIFT_WR);
    cmd.out_load   = (state == S_FIN) && !stat.out_busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            unique case (in_func)
              FUNC_REPORT: state <= S_EV_WR;
              FUNC_QUERY, FUNC_LIFT: state <= stat.bn_empty ? S_FIN : S_BN_SCAN;
              default: state <= S_FIN;
            endcase
          end
        end
        S_EV_WR:    state <= S_EV_SCAN;
        S_EV_SCAN:  if (stat.ev_last) state <= S_EV_DRAIN;
        S_EV_DRAIN: state <= S_DECIDE;
        S_DECIDE:   state <= S_FIN;
        S_BN_SCAN:  if (stat.bn_last) state <= S_BN_DRAIN;
        S_BN_DRAIN: state <= S_BN_DONE;
        S_BN_DONE: begin
          if (stat.func == FUNC_LIFT && stat.lift_found) state <= S_LIFT_RD;
          else state <= S_FIN;
        end
        S_LIFT_RD:  state <= S_LIFT_WR;
        S_LIFT_WR:  state <= S_FIN;
        S_FIN:      if (!stat.out_busy) state <= S_IDLE;
        default:    state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/iperq_dp.sv
module iperq_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [iperq_pkg::IN_W-1:0]         in_data,
  input  logic                               cfg_valid,
  input  logic [iperq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [iperq_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [iperq_pkg::OUT_W-1:0]        out_data,
  input  iperq_pkg::ctrl_cmd_t               cmd,
  output iperq_pkg::dp_stat_t                stat
);
  import iperq_pkg::*;

  // configuration
  logic [LIMIT_W-1:0] event_limit;
  logic [SEC_W-1:0]   window_seconds;
  logic [SEC_W-1:0]   ban_seconds;

  always_ff @(posedge clk) begin
    if (rst) begin
      event_limit    <= LIMIT_RST;
      window_seconds <= WINDOW_RST;
      ban_seconds    <= BAN_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_EVENT_LIMIT: event_limit    <= cfg_data[LIMIT_W-1:0];
        CFG_WINDOW:      window_seconds <= cfg_data;
        CFG_BAN_TIME:    ban_seconds    <= cfg_data;
        default: ;
      endcase
    end
  end

  // item latch
  logic [FUNC_W-1:0] func;
  logic [ADDR_W-1:0] ip;
  logic [TIME_W-1:0] now;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func <= in_data[FUNC_W-1:0];
      ip   <= in_data[FUNC_W +: ADDR_W];
      now  <= in_data[FUNC_W+ADDR_W +: TIME_W];
    end
  end

  // event ring
  logic [ADDR_W+TIME_W-1:0] ev_mem [EVENT_DEPTH];
  logic [ADDR_W+TIME_W-1:0] ev_q;
  logic [EVENT_DEPTH-1:0]   ev_valid;
  logic                     ev_vld_q;
  logic [EV_AW-1:0]         ev_head;
  logic [EV_AW-1:0]         ev_idx;
  logic                     ev_pend;

  always_ff @(posedge clk) begin
    if (cmd.ev_wr) ev_mem[ev_head] <= {now, ip};
    if (cmd.ev_rd) begin
      ev_q     <= ev_mem[ev_idx];
      ev_vld_q <= ev_valid[ev_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= '0;
      ev_head  <= '0;
      ev_idx   <= '0;
      ev_pend  <= 1'b0;
    end else begin
      ev_pend <= cmd.ev_rd;
      if (cmd.capture) ev_idx <= '0;
      else if (cmd.ev_rd) ev_idx <= ev_idx + EV_AW'(1);
      if (cmd.ev_wr) begin
        ev_valid[ev_head] <= 1'b1;
        ev_head <= (ev_head == EV_AW'(EVENT_DEPTH - 1)) ? '0 : ev_head + EV_AW'(1);
      end
    end
  end

  logic [TIME_W-1:0] ev_age;
  logic              ev_hit;
  assign ev_age = now - ev_q[ADDR_W +: TIME_W];
  assign ev_hit = ev_pend && ev_vld_q && (ev_q[ADDR_W-1:0] == ip)
                  && (ev_age < TIME_W'(window_seconds));

  // ban table
  logic [ADDR_W+TIME_W-1:0] bn_mem [BAN_DEPTH];
  logic [ADDR_W+TIME_W-1:0] bn_q;
  logic [BN_CW-1:0]         ban_used;
  logic [BN_AW-1:0]         bn_idx;
  logic [BN_AW-1:0]         bn_ridx;
  logic [BN_AW-1:0]         bn_match;
  logic [BN_AW-1:0]         bn_last_addr;
  logic                     bn_pend;
  logic                     bn_full;
  logic [TIME_W:0]          exp_sum;
  logic [TIME_W-1:0]        expiry;
  logic [COUNT_W-1:0]       cnt;
  logic                     ban_due;

  assign bn_last_addr = BN_AW'(ban_used - BN_CW'(1));
  assign bn_full      = (ban_used == BN_CW'(BAN_DEPTH));
  assign exp_sum      = {1'b0, now} + (TIME_W+1)'(ban_seconds);
  assign expiry       = exp_sum[TIME_W] ? '1 : exp_sum[TIME_W-1:0];
  assign ban_due      = (cnt >= COUNT_W'(event_limit));

  always_ff @(posedge clk) begin
    if (cmd.decide && ban_due && !bn_full) bn_mem[BN_AW'(ban_used)] <= {expiry, ip};
    else if (cmd.lift_wr) bn_mem[bn_match] <= bn_q;
    if (cmd.bn_rd) begin
      bn_q    <= bn_mem[bn_idx];
      bn_ridx <= bn_idx;
    end else if (cmd.bn_rd_last) begin
      bn_q <= bn_mem[bn_last_addr];
    end
  end

  logic bn_hit_addr;
  assign bn_hit_addr = bn_pend && (bn_q[ADDR_W-1:0] == ip);

  // per-item results
  logic is_banned, ban_added, ban_table_full, entry_removed;

  always_ff @(posedge clk) begin
    if (rst) begin
      ban_used <= '0;
      bn_idx   <= '0;
      bn_pend  <= 1'b0;
    end else begin
      bn_pend <= cmd.bn_rd;
      if (cmd.capture) bn_idx <= '0;
      else if (cmd.bn_rd) bn_idx <= bn_idx + BN_AW'(1);
      if (cmd.decide && ban_due && !bn_full) ban_used <= ban_used + BN_CW'(1);
      else if (cmd.lift_wr) ban_used <= ban_used - BN_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cnt            <= '0;
      is_banned      <= 1'b0;
      ban_added      <= 1'b0;
      ban_table_full <= 1'b0;
      entry_removed  <= 1'b0;
    end else begin
      if (ev_hit && cnt != COUNT_MAX) cnt <= cnt + COUNT_W'(1);
      if (bn_hit_addr && func == FUNC_QUERY && now < bn_q[ADDR_W +: TIME_W]) is_banned <= 1'b1;
      if (bn_hit_addr && func == FUNC_LIFT && !entry_removed) begin
        entry_removed <= 1'b1;
        bn_match      <= bn_ridx;
      end
      if (cmd.decide && ban_due) begin
        ban_added      <= !bn_full;
        ban_table_full <= bn_full;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= {5'd0, entry_removed, ban_table_full, cnt, ban_added, is_banned};
    end
  end

  assign stat.func       = func;
  assign stat.ev_last    = (ev_idx == EV_AW'(EVENT_DEPTH - 1));
  assign stat.bn_last    = (BN_CW'(bn_idx) == ban_used - BN_CW'(1));
  assign stat.bn_empty   = (ban_used == '0);
  assign stat.lift_found = entry_removed;
  assign stat.out_busy   = out_valid && !out_ready;
  assign stat.ban_used   = ban_used;

endmodule

FILE: hw/rtl/ip_event_rate_quarantine.sv
// IP event-rate quarantine. A report (func 0) logs a block event for the source address
// in a 64-entry ring, then counts that address's events younger than window_seconds;
// when the count reaches event_limit a ban entry expiring at now + ban_seconds
// (saturating) is appended to a 16-entry table, or ban_table_full is flagged. A query
// (func 1) reports whether an unexpired ban for the address exists; a lift (func 2)
// removes the first ban entry for the address. A report writes its event, then scans the
// event ring one entry per cycle through its single read port and then decides. A query
// or a lift scans the used ban table entries; a lift that finds an entry then moves the
// last entry into its slot. With an empty table, and for the unused code 3, an item goes
// straight to the result. The result is loaded into an output register and input is
// taken again on the next cycle; a result still waiting there holds back the next load
// and with it the input. Configuration writes are accepted outside reset and belong
// between items, with no item in flight.
module ip_event_rate_quarantine (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // func[1:0], ip_addr[33:2], now_seconds[65:34], zero pad
  input  logic [iperq_pkg::IN_W-1:0]          s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // is_banned[0], ban_added[1], recent_count[8:2], ban_table_full[9],
  // entry_removed[10], zero pad
  output logic [iperq_pkg::OUT_W-1:0]         m_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [iperq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [iperq_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import iperq_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign cfg_ready = !rst;

  iperq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_func  (s_tdata[FUNC_W-1:0]),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  iperq_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .cmd       (cmd),
    .stat      (stat)
  );

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    stat.ban_used <= BN_CW'(BAN_DEPTH))
    else $error("ban table count beyond depth");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken again before item finished");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> m_tvalid)
    else $error("result load did not raise output valid");

  a_add_full_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[1] && m_tdata[9]))
    else $error("ban added and table full in one result");

endmodule

FILE: dv/tb_ip_event_rate_quarantine.sv
`timescale 1ns / 100ps

module tb_ip_event_rate_quarantine;
  import iperq_pkg::*;

  localparam logic [FUNC_W-1:0]    FUNC_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NONE    = 2'd3;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 180;

  typedef struct packed {
    logic [5:0]        pad;
    logic [TIME_W-1:0] now;
    logic [ADDR_W-1:0] ip;
    logic [FUNC_W-1:0] func;
  } request_t;

  typedef struct packed {
    logic [4:0]         pad;
    logic               entry_removed;
    logic               ban_table_full;
    logic [COUNT_W-1:0] recent_count;
    logic               ban_added;
    logic               is_banned;
  } verdict_t;

  class quarantine_board;
    logic [LIMIT_W-1:0] limit;
    logic [SEC_W-1:0]   window;
    logic [SEC_W-1:0]   ban_len;
    logic [ADDR_W-1:0]  ev_ip[EVENT_DEPTH];
    logic [TIME_W-1:0]  ev_stamp[EVENT_DEPTH];
    bit                 ev_live[EVENT_DEPTH];
    int unsigned        ev_head;
    logic [ADDR_W-1:0]  ban_ip[BAN_DEPTH];
    logic [TIME_W-1:0]  ban_until[BAN_DEPTH];
    int unsigned        ban_cnt;
    verdict_t           verdicts[$];
    int                 errors;

    function new();
      limit   = LIMIT_RST;
      window  = WINDOW_RST;
      ban_len = BAN_RST;
      for (int i = 0; i < EVENT_DEPTH; i++) ev_live[i] = 0;
      ev_head = 0;
      ban_cnt = 0;
      errors  = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_EVENT_LIMIT: limit   = val[LIMIT_W-1:0];
        CFG_WINDOW:      window  = val[SEC_W-1:0];
        CFG_BAN_TIME:    ban_len = val[SEC_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_item(logic [FUNC_W-1:0] op, logic [ADDR_W-1:0] ip,
                            logic [TIME_W-1:0] now);
      verdict_t          v;
      logic [TIME_W-1:0] age;
      logic [TIME_W:0]   ban_end;
      int unsigned       n;
      bit                found;
      v = '0;
      n = 0;
      found = 0;
      case (op)
        FUNC_REPORT: begin
          ev_ip[ev_head]    = ip;
          ev_stamp[ev_head] = now;
          ev_live[ev_head]  = 1;
          ev_head = (ev_head + 1) % EVENT_DEPTH;
          for (int i = 0; i < EVENT_DEPTH; i++) begin
            age = now - ev_stamp[i];
            if (ev_live[i] && ev_ip[i] == ip && age < window && n < COUNT_MAX) n++;
          end
          v.recent_count = COUNT_W'(n);
          if (n >= limit) begin
            if (ban_cnt < BAN_DEPTH) begin
              ban_end = {1'b0, now} + (TIME_W+1)'(ban_len);
              if (ban_end[TIME_W]) ban_end = {1'b0, {TIME_W{1'b1}}};
              ban_ip[ban_cnt]    = ip;
              ban_until[ban_cnt] = ban_end[TIME_W-1:0];
              ban_cnt++;
              v.ban_added = 1;
            end else begin
              v.ban_table_full = 1;
            end
          end
        end
        FUNC_QUERY: begin
          for (int i = 0; i < ban_cnt; i++)
            if (!found && ban_ip[i] == ip && now < ban_until[i]) found = 1;
          v.is_banned = found;
        end
        FUNC_LIFT: begin
          for (int i = 0; i < ban_cnt; i++) begin
            if (!found && ban_ip[i] == ip) begin
              found        = 1;
              ban_ip[i]    = ban_ip[ban_cnt-1];
              ban_until[i] = ban_until[ban_cnt-1];
            end
          end
          if (found) ban_cnt--;
          v.entry_removed = found;
        end
        default: ;
      endcase
      verdicts.push_back(v);
    endfunction

    function void cmp(string what, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t mismatch %s: expected %0d actual %0d", $time, what, want, got);
      end
    endfunction

    function void check_result(logic [OUT_W-1:0] data);
      verdict_t want;
      verdict_t got;
      got = data;
      if (verdicts.size() == 0) begin
        errors++;
        $display("%0t unexpected beat: expected none actual %h", $time, data);
      end else begin
        want = verdicts.pop_front();
        cmp("is_banned", want.is_banned, got.is_banned);
        cmp("ban_added", want.ban_added, got.ban_added);
        cmp("recent_count", want.recent_count, got.recent_count);
        cmp("ban_table_full", want.ban_table_full, got.ban_table_full);
        cmp("entry_removed", want.entry_removed, got.entry_removed);
        cmp("pad", want.pad, got.pad);
      end
    endfunction

    function int pending();
      return verdicts.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_W-1:0]       s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_W-1:0]      m_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  quarantine_board board;
  int  send_gap_pct;
  int  stall_pct;
  bit  hold_req;

  ip_event_rate_quarantine uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  // downstream side
  initial begin
    m_tready = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready <= 0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_result(m_tdata);
  end

  task automatic send_item(logic [FUNC_W-1:0] op, logic [ADDR_W-1:0] ip,
                           logic [TIME_W-1:0] now);
    request_t req;
    req.pad  = '0;
    req.now  = now;
    req.ip   = ip;
    req.func = op;
    @(negedge clk);
    while (send_gap_pct > 0 && $urandom_range(0, 99) < send_gap_pct) begin
      s_tvalid <= 0;
      @(negedge clk);
    end
    s_tvalid <= 1;
    s_tdata  <= req;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_item(op, ip, now);
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid <= 0;
    while (board.pending() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic set_limits(int lim, int win, int ban);
    write_reg(CFG_EVENT_LIMIT, CFG_DATA_W'(lim));
    write_reg(CFG_WINDOW, CFG_DATA_W'(win));
    write_reg(CFG_BAN_TIME, CFG_DATA_W'(ban));
  endtask

  task automatic run_phase(int idx, int pool_n, logic [TIME_W-1:0] start);
    logic [ADDR_W-1:0] pool[8];
    logic [TIME_W-1:0] wall;
    logic [TIME_W-1:0] stamp;
    logic [FUNC_W-1:0] op;
    logic [ADDR_W-1:0] ip;
    int                r;
    case (idx % 4)
      0: begin send_gap_pct = 0;  stall_pct = 0;  end
      1: begin send_gap_pct = 57; stall_pct = 0;  end
      2: begin send_gap_pct = 0;  stall_pct = 57; end
      default: begin send_gap_pct = 8; stall_pct = 8; end
    endcase
    pool[0] = $urandom();
    pool[1] = pool[0] ^ 32'h1;
    for (int i = 2; i < 8; i++) pool[i] = $urandom();
    wall = start;
    for (int k = 0; k < PHASE_ITEMS; k++) begin
      if (k == PHASE_ITEMS / 2 && idx == 0) hold_req = 1;
      if (k == PHASE_ITEMS / 2 && idx == 5) drain();
      r = $urandom_range(0, 99);
      op = (r < 50) ? FUNC_REPORT : (r < 75) ? FUNC_QUERY : (r < 94) ? FUNC_LIFT
                                                                     : FUNC_UNUSED;
      ip = ($urandom_range(0, 99) < 88) ? pool[$urandom_range(0, pool_n - 1)]
                                        : $urandom();
      r = $urandom_range(0, 99);
      if (r < 70) wall = wall + $urandom_range(0, 2);
      else if (r < 85) wall = wall + $urandom_range(0, 2 * board.window + 1);
      else if (r < 93) wall = wall - $urandom_range(0, 50);
      else if (r < 98) wall = wall;
      else wall = $urandom();
      stamp = (r >= 93 && r < 98) ? $urandom() : wall;
      send_item(op, ip, stamp);
    end
  endtask

  initial begin
    board        = new();
    rst          = 1;
    s_tvalid     = 0;
    s_tdata      = '0;
    cfg_valid    = 0;
    cfg_index    = '0;
    cfg_data     = '0;
    send_gap_pct = 0;
    stall_pct    = 0;
    hold_req     = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // reset settings: five quick reports trigger a ban
    for (int k = 0; k < 5; k++) send_item(FUNC_REPORT, 32'h0A00_0001, 32'd100 + k);
    send_item(FUNC_QUERY, 32'h0A00_0001, 32'd105);
    send_item(FUNC_QUERY, 32'h0A00_0001, 32'd704);
    send_item(FUNC_QUERY, 32'h0A00_0000, 32'd105);
    send_item(FUNC_REPORT, 32'h0A00_0001, 32'd50);
    send_item(FUNC_LIFT, 32'h0A00_0001, 32'd0);
    send_item(FUNC_LIFT, 32'h0A00_0001, 32'd0);
    send_item(FUNC_UNUSED, '1, '1);
    send_item(FUNC_REPORT, '0, '0);
    send_item(FUNC_REPORT, '1, '1);
    drain();
    // zero limit, saturating expiry, ignored index
    set_limits(0, 16'hFFFF, 16'hFFFF);
    write_reg(CFG_NONE, 16'h1234);
    send_item(FUNC_REPORT, 32'hC0A8_0101, 32'hFFFF_FFF0);
    send_item(FUNC_QUERY, 32'hC0A8_0101, 32'hFFFF_FFFE);
    send_item(FUNC_LIFT, 32'hC0A8_0101, 32'd0);
    drain();
    // zero window, limit masked to one
    write_reg(CFG_WINDOW, 16'd0);
    write_reg(CFG_EVENT_LIMIT, 16'hFF81);
    send_item(FUNC_REPORT, 32'hC0A8_0101, 32'd7);
    send_item(FUNC_REPORT, 32'hC0A8_0101, 32'd7);

    for (int p = 0; p < 8; p++) begin
      drain();
      case (p)
        0: begin set_limits(1, 10, 30);         run_phase(p, 8, $urandom()); end
        1: begin set_limits(3, 65535, 65535);   run_phase(p, 3, 32'hFFFF_FF00); end
        2: begin set_limits(64, 65535, 1);      run_phase(p, 1, $urandom()); end
        3: begin set_limits(5, 60, 600);        run_phase(p, 4, $urandom()); end
        4: begin set_limits(2, 1, 200);         run_phase(p, 2, $urandom()); end
        6: begin set_limits(0, 100, 50);        run_phase(p, 5, $urandom()); end
        default: begin
          set_limits($urandom_range(1, 8), $urandom_range(1, 300), $urandom_range(1, 2000));
          run_phase(p, $urandom_range(3, 6), $urandom());
        end
      endcase
    end

    send_gap_pct = 0;
    drain();
    repeat (100) @(negedge clk);
    if (board.errors == 0 && board.pending() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
